// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the I2C master RTL.
// Depends on clk and rst being visible in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/i2cbm_pkg.sv -----
// Package for the I2C bit-level master: command codes, queue item and result types.
// No dependencies.
package i2cbm_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_RACK  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_NOP  = 2'd2
  } kind_t;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd10;

  typedef struct packed {
    kind_t      kind;
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       ack_bit;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_in;
  } result_t;

  function automatic logic [4:0] phase_total(cmd_t c);
    logic [4:0] n;
    n = 5'd0;
    unique case (c)
      CMD_START: n = 5'd4;
      CMD_STOP:  n = 5'd3;
      CMD_WRITE: n = 5'd24;
      CMD_READ:  n = 5'd25;
      CMD_SACK:  n = 5'd3;
      CMD_RACK:  n = 5'd4;
      default:   n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/i2c_bit_level_master_unit.sv -----
// I2C bit-level master, top level. Depends on i2cbm_pkg, i2cbm_front, i2cbm_engine.
// A pushed item waits in the front queue; the engine steps once per item and
// registers its result in the result queue, whose head drives the result ports.
// One item per cycle while no queue is full; 2-entry queues decouple push and pop.
// Reset (rst, synchronous): queues empty, idle, SCL/SDA released, phase_ticks = 10.
module i2c_bit_level_master_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type,
  input  logic [7:0]  data_byte,
  input  logic        ack_bit,
  input  logic        sda_in,
  output logic        empty,
  input  logic        pop,
  output logic        scl_out,
  output logic        sda_out,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_data,
  output logic        ack_in
);
  import i2cbm_pkg::*;

  logic [15:0] phase_ticks;
  logic        item_valid;
  logic        item_ready;
  item_t       item;
  result_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RST;
    end else if (cfg_wr) begin
      phase_ticks <= cfg_data;
    end
  end

  i2cbm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .data_byte (data_byte),
    .ack_bit   (ack_bit),
    .sda_in    (sda_in),
    .out_valid (item_valid),
    .out_ready (item_ready),
    .out_item  (item)
  );

  i2cbm_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .phase_ticks (phase_ticks),
    .in_valid    (item_valid),
    .in_ready    (item_ready),
    .in_item     (item),
    .empty       (empty),
    .pop         (pop),
    .res         (res)
  );

  assign scl_out   = res.scl_out;
  assign sda_out   = res.sda_out;
  assign busy_res  = res.busy_res;
  assign done_res  = res.done_res;
  assign read_data = res.read_data;
  assign ack_in    = res.ack_in;

endmodule

// ----- rtl/i2cbm_front.sv -----
// Front end: classifies incoming requests and holds them in a two-entry queue.
// Depends on i2cbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cbm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        req_type,
  input  logic [7:0]        data_byte,
  input  logic              ack_bit,
  input  logic              sda_in,
  output logic              out_valid,
  input  logic              out_ready,
  output i2cbm_pkg::item_t  out_item
);
  import i2cbm_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push_acc;
  logic       pop_acc;
  item_t      cls;

  always_comb begin
    cls.data_byte = data_byte;
    cls.ack_bit   = ack_bit;
    cls.sda_in    = sda_in;
    cls.kind      = KIND_NOP;
    cls.cmd       = CMD_IDLE;
    unique case (req_type)
      3'd0: cls.kind = KIND_TICK;
      3'd1: begin cls.kind = KIND_CMD; cls.cmd = CMD_START; end
      3'd2: begin cls.kind = KIND_CMD; cls.cmd = CMD_STOP;  end
      3'd3: begin cls.kind = KIND_CMD; cls.cmd = CMD_WRITE; end
      3'd4: begin cls.kind = KIND_CMD; cls.cmd = CMD_READ;  end
      3'd5: begin cls.kind = KIND_CMD; cls.cmd = CMD_SACK;  end
      3'd6: begin cls.kind = KIND_CMD; cls.cmd = CMD_RACK;  end
      default: cls.kind = KIND_NOP;
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_item  = q[rd_ptr];
  assign push_acc  = push & ~full;
  assign pop_acc   = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (push_acc) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push_acc) wr_ptr <= ~wr_ptr;
      if (pop_acc) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, push_acc} - {1'b0, pop_acc};
    end
  end

  `CHK_ALWAYS(a_front_cnt, cnt <= 2'd2, "front queue count out of range")
  `CHK_NEXT(a_front_fill, push_acc && !pop_acc, cnt == $past(cnt) + 2'd1, "front queue lost an item")

endmodule

// ----- rtl/i2cbm_engine.sv -----
// Back end: plays commands out as SCL/SDA pin phases and queues one result per item.
// Depends on i2cbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cbm_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        phase_ticks,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2cbm_pkg::item_t   in_item,
  output logic               empty,
  input  logic               pop,
  output i2cbm_pkg::result_t res
);
  import i2cbm_pkg::*;

  cmd_t        cmd, cmd_next;
  logic [4:0]  phase, phase_next;
  logic [15:0] tick, tick_next;
  logic [7:0]  shift, shift_next;
  logic [1:0]  sub, sub_next;
  logic        scl, scl_next;
  logic        sda, sda_next;
  logic        ack_seen, ack_seen_next;
  logic [7:0]  read_hold, read_hold_next;
  logic        done_next;

  logic [15:0] limit;
  logic [15:0] tick_inc;
  logic [4:0]  phase_inc;
  logic [1:0]  sub_inc;
  logic        step;

  result_t     q [2];
  result_t     res_in;
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  cnt;
  logic        pop_acc;

  assign limit     = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign tick_inc  = tick + 16'd1;
  assign phase_inc = phase + 5'd1;
  assign sub_inc   = (sub == 2'd2) ? 2'd0 : sub + 2'd1;

  always_comb begin
    cmd_next       = cmd;
    phase_next     = phase;
    tick_next      = tick;
    shift_next     = shift;
    sub_next       = sub;
    scl_next       = scl;
    sda_next       = sda;
    ack_seen_next  = ack_seen;
    read_hold_next = read_hold;
    done_next      = 1'b0;
    if (cmd == CMD_IDLE) begin
      if (in_item.kind == KIND_CMD) begin
        cmd_next   = in_item.cmd;
        phase_next = 5'd0;
        tick_next  = 16'd0;
        // read phases count in groups of three starting at phase one
        sub_next   = (in_item.cmd == CMD_READ) ? 2'd2 : 2'd0;
        unique case (in_item.cmd)
          CMD_STOP:  sda_next = 1'b0;
          CMD_WRITE: begin
            shift_next = in_item.data_byte;
            sda_next   = in_item.data_byte[7];
          end
          CMD_READ: begin
            shift_next = 8'd0;
            sda_next   = 1'b1;
          end
          CMD_SACK:  sda_next = in_item.ack_bit;
          default:   sda_next = 1'b1;
        endcase
      end
    end else if (in_item.kind == KIND_TICK) begin
      if (tick_inc >= limit) begin
        tick_next = 16'd0;
        if (cmd == CMD_READ && sub == 2'd1) shift_next = {shift[6:0], in_item.sda_in};
        if (cmd == CMD_RACK && phase == 5'd2) ack_seen_next = in_item.sda_in;
        if (phase_inc >= phase_total(cmd)) begin
          done_next  = 1'b1;
          cmd_next   = CMD_IDLE;
          phase_next = 5'd0;
          if (cmd == CMD_READ) read_hold_next = shift_next;
        end else begin
          phase_next = phase_inc;
          sub_next   = sub_inc;
          unique case (cmd)
            CMD_START: begin
              if (phase_inc == 5'd1) scl_next = 1'b1;
              else if (phase_inc == 5'd2) sda_next = 1'b0;
              else scl_next = 1'b0;
            end
            CMD_STOP: begin
              if (phase_inc == 5'd1) scl_next = 1'b1;
              else sda_next = 1'b1;
            end
            CMD_WRITE: begin
              if (sub_inc == 2'd0) begin
                shift_next = {shift[6:0], 1'b0};
                sda_next   = shift[6];
              end else begin
                scl_next = (sub_inc == 2'd1);
              end
            end
            CMD_READ: begin
              if (sub_inc == 2'd0) scl_next = 1'b1;
              else if (sub_inc == 2'd2) scl_next = 1'b0;
            end
            CMD_SACK: scl_next = (phase_inc == 5'd1);
            CMD_RACK: begin
              if (phase_inc == 5'd1) scl_next = 1'b1;
              else if (phase_inc == 5'd3) scl_next = 1'b0;
            end
            default: ;
          endcase
        end
      end else begin
        tick_next = tick_inc;
      end
    end
  end

  assign empty    = (cnt == 2'd0);
  assign pop_acc  = pop & ~empty;
  assign in_ready = (cnt != 2'd2) | pop;
  assign step     = in_valid & in_ready;
  assign res      = q[rd_ptr];

  always_comb begin
    res_in.scl_out   = scl_next;
    res_in.sda_out   = sda_next;
    res_in.busy_res  = (cmd_next != CMD_IDLE);
    res_in.done_res  = done_next;
    res_in.read_data = read_hold_next;
    res_in.ack_in    = ack_seen_next;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      q[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd       <= CMD_IDLE;
      phase     <= 5'd0;
      tick      <= 16'd0;
      shift     <= 8'd0;
      sub       <= 2'd0;
      scl       <= 1'b1;
      sda       <= 1'b1;
      ack_seen  <= 1'b0;
      read_hold <= 8'd0;
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      cnt       <= 2'd0;
    end else begin
      if (step) begin
        cmd       <= cmd_next;
        phase     <= phase_next;
        tick      <= tick_next;
        shift     <= shift_next;
        sub       <= sub_next;
        scl       <= scl_next;
        sda       <= sda_next;
        ack_seen  <= ack_seen_next;
        read_hold <= read_hold_next;
        wr_ptr    <= ~wr_ptr;
      end
      if (pop_acc) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, step} - {1'b0, pop_acc};
    end
  end

  `CHK_ALWAYS(a_phase_range, cmd == CMD_IDLE || phase < phase_total(cmd), "phase past end")
  `CHK_ALWAYS(a_tick_idle, cmd != CMD_IDLE || tick == 16'd0, "tick count left while idle")
  `CHK_NEXT(a_done_idle, step && done_next, cmd == CMD_IDLE && !empty, "done without idle")

endmodule

// ----- bench/i2cbm_checker.sv -----
`timescale 1ns / 100ps
// Checker for i2c_bit_level_master_unit: watches the item and result queues, predicts
// each result from the accepted items and compares it. Depends on i2cbm_pkg.
module i2cbm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [15:0] cfg_data,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  req_type,
  input  logic [7:0]  data_byte,
  input  logic        ack_bit,
  input  logic        sda_in,
  input  logic        pop,
  input  logic        empty,
  input  logic        scl_out,
  input  logic        sda_out,
  input  logic        busy_res,
  input  logic        done_res,
  input  logic [7:0]  read_data,
  input  logic        ack_in,
  output int          outstanding,
  output int          fail_count
);
  import i2cbm_pkg::*;

  logic [15:0] ticks_per_phase;
  cmd_t        cur_cmd;
  logic [4:0]  cur_phase;
  int          tick_cnt;
  logic [7:0]  shreg;
  logic [7:0]  last_read;
  logic        scl_lvl;
  logic        sda_lvl;
  logic        ack_lvl;
  logic        ack_drv;

  result_t     pin_results_q[$];
  result_t     got;
  result_t     want;

  initial begin
    outstanding = 0;
    fail_count = 0;
  end

  function automatic logic [4:0] phases_of(cmd_t c);
    case (c)
      CMD_START: return 5'd4;
      CMD_STOP:  return 5'd3;
      CMD_WRITE: return 5'd24;
      CMD_READ:  return 5'd25;
      CMD_SACK:  return 5'd3;
      CMD_RACK:  return 5'd4;
      default:   return 5'd0;
    endcase
  endfunction

  function automatic bit samples_sda(cmd_t c, logic [4:0] p);
    if (c == CMD_READ) return (p >= 1) && (((p - 1) % 3) == 1);
    if (c == CMD_RACK) return p == 2;
    return 1'b0;
  endfunction

  // pin action that opens phase p
  task automatic drive_phase(input cmd_t c, input logic [4:0] p);
    case (c)
      CMD_START: begin
        case (p)
          5'd0: sda_lvl = 1'b1;
          5'd1: scl_lvl = 1'b1;
          5'd2: sda_lvl = 1'b0;
          default: scl_lvl = 1'b0;
        endcase
      end
      CMD_STOP: begin
        case (p)
          5'd0: sda_lvl = 1'b0;
          5'd1: scl_lvl = 1'b1;
          default: sda_lvl = 1'b1;
        endcase
      end
      CMD_WRITE: begin
        case (p % 3)
          0: sda_lvl = shreg[7 - p / 3];
          1: scl_lvl = 1'b1;
          default: scl_lvl = 1'b0;
        endcase
      end
      CMD_READ: begin
        if (p == 0) begin
          sda_lvl = 1'b1;
        end else begin
          case ((p - 1) % 3)
            0: scl_lvl = 1'b1;
            2: scl_lvl = 1'b0;
            default: ;
          endcase
        end
      end
      CMD_SACK: begin
        case (p)
          5'd0: sda_lvl = ack_drv;
          5'd1: scl_lvl = 1'b1;
          default: scl_lvl = 1'b0;
        endcase
      end
      CMD_RACK: begin
        case (p)
          5'd0: sda_lvl = 1'b1;
          5'd1: scl_lvl = 1'b1;
          5'd3: scl_lvl = 1'b0;
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic apply_item(input logic [2:0] req, input logic [7:0] d, input logic a,
                            input logic s, output result_t r);
    int   lim;
    logic finished;
    lim = (ticks_per_phase == 16'd0) ? 1 : int'(ticks_per_phase);
    finished = 1'b0;
    if (cur_cmd == CMD_IDLE) begin
      if (req >= CMD_START && req <= CMD_RACK) begin
        cur_cmd = cmd_t'(req);
        cur_phase = 5'd0;
        tick_cnt = 0;
        if (cur_cmd == CMD_WRITE) shreg = d;
        else if (cur_cmd == CMD_READ) shreg = 8'h00;
        if (cur_cmd == CMD_SACK) ack_drv = a;
        drive_phase(cur_cmd, 5'd0);
      end
    end else if (req == CMD_IDLE) begin
      // code zero is a tick
      tick_cnt++;
      if (tick_cnt >= lim) begin
        tick_cnt = 0;
        if (samples_sda(cur_cmd, cur_phase)) begin
          if (cur_cmd == CMD_READ) shreg = {shreg[6:0], s};
          else ack_lvl = s;
        end
        cur_phase++;
        if (cur_phase >= phases_of(cur_cmd)) begin
          if (cur_cmd == CMD_READ) last_read = shreg;
          finished = 1'b1;
          cur_cmd = CMD_IDLE;
          cur_phase = 5'd0;
        end else begin
          drive_phase(cur_cmd, cur_phase);
        end
      end
    end
    r.scl_out   = scl_lvl;
    r.sda_out   = sda_lvl;
    r.busy_res  = (cur_cmd != CMD_IDLE);
    r.done_res  = finished;
    r.read_data = last_read;
    r.ack_in    = ack_lvl;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ticks_per_phase = PHASE_TICKS_RST;
      cur_cmd = CMD_IDLE;
      cur_phase = 5'd0;
      tick_cnt = 0;
      shreg = 8'h00;
      last_read = 8'h00;
      scl_lvl = 1'b1;
      sda_lvl = 1'b1;
      ack_lvl = 1'b0;
      ack_drv = 1'b0;
      pin_results_q.delete();
    end else begin
      if (cfg_wr) ticks_per_phase = cfg_data;
      if (pop && !empty) begin
        got.scl_out   = scl_out;
        got.sda_out   = sda_out;
        got.busy_res  = busy_res;
        got.done_res  = done_res;
        got.read_data = read_data;
        got.ack_in    = ack_in;
        if (pin_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result transfer with nothing expected", $realtime);
        end else begin
          want = pin_results_q.pop_front();
          if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
              got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
              got.read_data !== want.read_data || got.ack_in !== want.ack_in) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("%0t: mismatch exp scl=%b sda=%b busy=%b done=%b rd=%h ack=%b",
                     $realtime, want.scl_out, want.sda_out, want.busy_res,
                     want.done_res, want.read_data, want.ack_in);
              $display(" got scl=%b sda=%b busy=%b done=%b rd=%h ack=%b",
                       got.scl_out, got.sda_out, got.busy_res, got.done_res,
                       got.read_data, got.ack_in);
            end
          end
        end
      end
      if (push && !full) begin
        apply_item(req_type, data_byte, ack_bit, sda_in, want);
        pin_results_q.push_back(want);
      end
    end
    outstanding <= pin_results_q.size();
  end

endmodule

// ----- bench/i2c_bit_level_master_unit_test.sv -----
`timescale 1ns / 100ps
// Testbench top for i2c_bit_level_master_unit: directed and random command/tick transfers,
// result-side stalls, verdict. Depends on i2cbm_pkg and i2cbm_checker.
module i2c_bit_level_master_unit_test;
  import i2cbm_pkg::*;

  localparam logic [2:0] REQ_TICK = CMD_IDLE;
  localparam logic [2:0] REQ_NOP  = 3'd7;

  typedef enum logic [1:0] {
    POP_FREE,
    POP_RANDOM,
    POP_PERIODIC
  } pop_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  req_type = '0;
  logic [7:0]  data_byte = '0;
  logic        ack_bit = 1'b0;
  logic        sda_in = 1'b1;
  logic        empty;
  logic        pop = 1'b0;
  logic        scl_out;
  logic        sda_out;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  read_data;
  logic        ack_in;

  int          outstanding;
  int          fail_count;

  logic        steady = 1'b0;
  int          burst_left = 0;
  int          ticks_now = 10;
  int          items_sent = 0;
  pop_mode_t   pop_mode = POP_FREE;
  int          mode_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_bit_level_master_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .req_type (req_type),
    .data_byte(data_byte),
    .ack_bit  (ack_bit),
    .sda_in   (sda_in),
    .empty    (empty),
    .pop      (pop),
    .scl_out  (scl_out),
    .sda_out  (sda_out),
    .busy_res (busy_res),
    .done_res (done_res),
    .read_data(read_data),
    .ack_in   (ack_in)
  );

  i2cbm_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .data_byte  (data_byte),
    .ack_bit    (ack_bit),
    .sda_in     (sda_in),
    .pop        (pop),
    .empty      (empty),
    .scl_out    (scl_out),
    .sda_out    (sda_out),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .read_data  (read_data),
    .ack_in     (ack_in),
    .outstanding(outstanding),
    .fail_count (fail_count)
  );

  // result side stalls
  always @(posedge clk) begin
    if (steady) begin
      pop <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        pop_mode = pop_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (pop_mode)
        POP_FREE:   pop <= 1'b1;
        POP_RANDOM: pop <= ($urandom_range(0, 2) != 0);
        default:    pop <= (mode_left % 7) < 3;
      endcase
    end
  end

  function automatic int seq_len(logic [2:0] c);
    case (c)
      CMD_START: return 4;
      CMD_STOP:  return 3;
      CMD_WRITE: return 24;
      CMD_READ:  return 25;
      CMD_SACK:  return 3;
      CMD_RACK:  return 4;
      default:   return 0;
    endcase
  endfunction

  task automatic send(input logic [2:0] r, input logic [7:0] d, input logic a,
                      input logic s);
    int gap;
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push <= 1'b1;
    req_type <= r;
    data_byte <= d;
    ack_bit <= a;
    sda_in <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    if (burst_left > 0) burst_left--;
    items_sent++;
  endtask

  task automatic tick(input logic s);
    send(REQ_TICK, 8'($urandom), 1'($urandom), s);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_phase_ticks(input logic [15:0] v);
    wait_drained();
    cfg_wr <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_wr <= 1'b0;
    ticks_now = v;
    burst_left = 0;
  endtask

  // whole commands with their ticks, plus ignored items and cut-short commands
  task automatic run_sequences(input int n_items);
    logic [2:0] c;
    logic [7:0] d;
    int         lim;
    int         n_ticks;
    int         k;
    int         sda_mode;
    int         n_target;
    bit         dangling;
    lim = (ticks_now == 0) ? 1 : ticks_now;
    dangling = 1'b0;
    n_target = items_sent + n_items;
    while (items_sent < n_target) begin
      c = 3'($urandom_range(1, 6));
      case ($urandom_range(0, 7))
        0: d = 8'h00;
        1: d = 8'hFF;
        default: d = 8'($urandom);
      endcase
      sda_mode = $urandom_range(0, 3);
      send(c, d, 1'($urandom), 1'($urandom));
      n_ticks = seq_len(c) * lim;
      dangling = ($urandom_range(0, 11) == 0);
      if (dangling) n_ticks = $urandom_range(0, n_ticks - 1);
      for (k = 0; k < n_ticks; k++) begin
        if ($urandom_range(0, 15) == 0)
          send(($urandom_range(0, 1) != 0) ? REQ_NOP : 3'($urandom_range(1, 6)),
               8'($urandom), 1'($urandom), 1'($urandom));
        case (sda_mode)
          0: tick(1'b0);
          1: tick(1'b1);
          default: tick(1'($urandom));
        endcase
      end
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) tick(1'($urandom));
    end
    if (dangling)
      repeat (25 * lim) tick(1'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    run_sequences(200);

    set_phase_ticks(16'd1);
    tick(1'b1);
    send(REQ_NOP, 8'hFF, 1'b1, 1'b1);
    send(CMD_START, 8'hFF, 1'b1, 1'b0);
    send(CMD_STOP, 8'h00, 1'b0, 1'b0);
    send(REQ_NOP, 8'h00, 1'b0, 1'b0);
    repeat (4) tick(1'b1);
    send(CMD_SACK, 8'h00, 1'b1, 1'b0);
    repeat (3) tick(1'b0);
    send(CMD_RACK, 8'h00, 1'b0, 1'b1);
    repeat (4) tick(1'b0);
    send(CMD_STOP, 8'hFF, 1'b0, 1'b1);
    repeat (3) tick(1'b1);
    run_sequences(300);

    set_phase_ticks(16'd0);
    run_sequences(200);
    set_phase_ticks(16'd3);
    run_sequences(200);
    set_phase_ticks(16'($urandom_range(2, 5)));
    run_sequences(120);

    // widest phase: a stop partly counted, then finished at one tick per phase
    steady <= 1'b1;
    set_phase_ticks(16'hFFFF);
    send(CMD_STOP, 8'($urandom), 1'($urandom), 1'($urandom));
    repeat (40) tick(1'($urandom));
    set_phase_ticks(16'd1);
    repeat (3) tick(1'($urandom));

    wait_drained();
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
